// ===== hw/rtl/u16u8_pkg.sv =====
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package u16u8_pkg;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [20:0] PLANE1     = 21'h10000;

	localparam int JOB_QUEUE_DEPTH = 2;
	localparam int JOB_BYTES       = 6;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} enc_t;

	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
		logic                      string_end;
	} job_t;

	function automatic enc_t encode_cp(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < 21'h80) begin
			e.b[0] = cp[7:0];
			e.n    = 3'd1;
		end else if (cp < 21'h800) begin
			e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			e.b[1] = 8'h80 | {2'b00, cp[5:0]};
			e.n    = 3'd2;
		end else if (cp < PLANE1) begin
			e.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			e.b[1] = 8'h80 | {2'b00, cp[11:6]};
			e.b[2] = 8'h80 | {2'b00, cp[5:0]};
			e.n    = 3'd3;
		end else begin
			e.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
			e.b[1] = 8'h80 | {2'b00, cp[17:12]};
			e.b[2] = 8'h80 | {2'b00, cp[11:6]};
			e.b[3] = 8'h80 | {2'b00, cp[5:0]};
			e.n    = 3'd4;
		end
		return e;
	endfunction

endpackage

// ===== hw/rtl/u16u8_front.sv =====
// Front end: takes code units, pairs surrogates and builds at most one byte job per beat.
// Depends on u16u8_pkg.
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        job_push,
	output job_t        job
);

	logic       held_q;
	logic [9:0] held_bits_q;
	logic       is_high;
	logic       is_low;
	logic       pair;
	logic       pre;
	logic       hold_new;
	logic       cur_emit;
	logic [20:0] cp;
	enc_t       enc;

	assign is_high  = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
	assign is_low   = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
	assign pair     = held_q && is_low;
	assign pre      = held_q && !is_low;
	assign hold_new = !pair && is_high && !string_end;
	assign cur_emit = !pair && !hold_new;
	assign cp       = pair ? (PLANE1 + {1'b0, held_bits_q, code_unit[9:0]})
	                       : {5'b00000, code_unit};
	assign enc      = encode_cp(cp);

	always_comb begin
		job            = '0;
		job.string_end = string_end;
		if (pre) begin
			job.bytes[0] = 8'hED;
			job.bytes[1] = 8'hA0 | {4'b0000, held_bits_q[9:6]};
			job.bytes[2] = 8'h80 | {2'b00, held_bits_q[5:0]};
			job.bytes[3] = enc.b[0];
			job.bytes[4] = enc.b[1];
			job.bytes[5] = enc.b[2];
			job.count    = 3'd3 + (cur_emit ? enc.n : 3'd0);
		end else begin
			job.bytes[0] = enc.b[0];
			job.bytes[1] = enc.b[1];
			job.bytes[2] = enc.b[2];
			job.bytes[3] = enc.b[3];
			job.count    = (pair || cur_emit) ? enc.n : 3'd0;
		end
	end

	assign job_push = accept && (pair || pre || cur_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (accept) begin
			held_q <= hold_new;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_new) begin
			held_bits_q <= code_unit[9:0];
		end
	end

`ifndef NO_ASSERTIONS
	a_end_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && string_end |=> !held_q)
		else $error("surrogate still held after end of string");
	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && string_end |-> job_push && job.count != 3'd0)
		else $error("end of string produced no bytes");
`endif

endmodule

// ===== hw/rtl/u16u8_queue.sv =====
// Small job queue between front and back end.
// Depends on u16u8_pkg.
module u16u8_queue
	import u16u8_pkg::*;
#(
	parameter int DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/u16u8_back.sv =====
// Back end: walks head job bytes into out_byte_q, one per cycle unless stalled.
// Depends on u16u8_pkg.
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  job_t       job,
	output logic       job_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       text_done
);

	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       text_done_q;
	logic       slot_free;
	logic       advance;
	logic       last;

	assign slot_free = !out_valid_q || pop;
	assign advance   = slot_free && job_valid;
	assign last      = (pos_q == job.count - 3'd1);
	assign job_pop   = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_q       <= last ? 3'd0 : pos_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q  <= job.bytes[pos_q];
			run_last_q  <= last;
			text_done_q <= last && job.string_end;
		end
	end

	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;
	assign text_done = text_done_q;

`ifndef NO_ASSERTIONS
	a_pos_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> pos_q < job.count && job.count <= 3'd6)
		else $error("byte position outside head job");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && text_done_q |-> run_last_q)
		else $error("end of text on a byte that does not close its beat");
`endif

endmodule

// ===== hw/rtl/utf16_to_utf8_transcoder.sv =====
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue, back end.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue, u16u8_back.
//
// Push one UTF-16 code unit per beat; UTF-8 bytes come out in order, one per cycle at
// most. A unit causes output bytes according to its kind: one to three for a
// plain unit, four for a surrogate pair (charged to the low half), none for a held high
// surrogate, and three more when a held high surrogate is flushed unpaired. The single
// byte-wide output register of the back end sets this rate; a queue of QUEUE_DEPTH jobs
// lets input beats continue while bytes drain. run_last marks the last byte of each
// input beat, text_done the last byte of the string.
module utf16_to_utf8_transcoder
	import u16u8_pkg::*;
#(
	parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        text_done
);

	logic accept;
	logic job_push;
	job_t job_in;
	logic job_valid;
	job_t job_head;
	logic job_pop;

	assign accept = push && !full;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.code_unit  (code_unit),
		.string_end (string_end),
		.job_push   (job_push),
		.job        (job_in)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job_in),
		.full     (full),
		.pop      (job_pop),
		.valid    (job_valid),
		.head     (job_head)
	);

	u16u8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.text_done (text_done)
	);

endmodule

// ===== bench/u16u8_checker.sv =====
// Scoreboard for the UTF-16 to UTF-8 transcoder: watches the unit and byte channels,
// predicts the bytes of every accepted unit and compares each popped beat in order.
// Depends on u16u8_pkg for the surrogate bounds.
module u16u8_checker
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [15:0] code_unit,
	input  logic        string_end,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_byte,
	input  logic        run_last,
	input  logic        text_done,
	output int          fail_count,
	output int          due_count,
	output int          bytes_checked
);

	typedef struct packed {
		logic [7:0] data;
		logic       unit_last;
		logic       text_last;
	} utf8_beat_t;

	utf8_beat_t utf8_due[$];
	logic [7:0] run_bytes[$];
	logic [9:0] held_bits;
	logic       holding;
	utf8_beat_t wanted;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] exp_val);
		$display("mismatch: %s at byte %0d, got %0h, want %0h",
			what, bytes_checked, got, exp_val);
		fail_count++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		run_bytes.insert(run_bytes.size(), b);
	endtask

	task automatic queue_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte({3'b110, cp[10:6]});
			add_byte({2'b10, cp[5:0]});
		end else if (cp < PLANE1) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
			add_byte({2'b10, cp[5:0]});
		end
	endtask

	task automatic transcode_unit(input logic [15:0] cu, input logic fin);
		logic is_high;
		logic is_low;
		logic paired;
		utf8_beat_t beat;
		run_bytes = {};
		is_high = cu >= HIGH_FIRST && cu <= HIGH_LAST;
		is_low  = cu >= LOW_FIRST && cu <= LOW_LAST;
		paired  = 1'b0;
		if (holding) begin
			holding = 1'b0;
			if (is_low) begin
				queue_code_point(PLANE1 + {1'b0, held_bits, cu[9:0]});
				paired = 1'b1;
			end else begin
				queue_code_point({5'b0, HIGH_FIRST[15:10], held_bits});
			end
			held_bits = '0;
		end
		if (!paired) begin
			if (is_high && !fin) begin
				held_bits = cu[9:0];
				holding   = 1'b1;
			end else begin
				queue_code_point({5'b0, cu});
			end
		end
		foreach (run_bytes[i]) begin
			beat.data      = run_bytes[i];
			beat.unit_last = (i == run_bytes.size() - 1);
			beat.text_last = beat.unit_last && fin;
			utf8_due.insert(utf8_due.size(), beat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_due      = {};
			held_bits     = '0;
			holding       = 1'b0;
			due_count     = 0;
			fail_count    = 0;
			bytes_checked = 0;
		end else begin
			if (push && !full)
				transcode_unit(code_unit, string_end);
			if (pop && !empty) begin
				if (utf8_due.size() == 0) begin
					report_mismatch("byte with nothing due", 16'(out_byte), 16'h0);
				end else begin
					wanted = utf8_due.pop_front();
					if (out_byte !== wanted.data)
						report_mismatch("out_byte", 16'(out_byte), 16'(wanted.data));
					if (run_last !== wanted.unit_last)
						report_mismatch("run_last", 16'(run_last),
							16'(wanted.unit_last));
					if (text_done !== wanted.text_last)
						report_mismatch("text_done", 16'(text_done),
							16'(wanted.text_last));
				end
				bytes_checked++;
			end
			due_count = utf8_due.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the transcoder bench: clock, reset, code unit stimulus and byte drain.
// Depends on u16u8_pkg, utf16_to_utf8_transcoder and u16u8_checker.
module testbench;
	import u16u8_pkg::*;

	typedef enum int {
		UC_ASCII,
		UC_TWO_BYTE,
		UC_THREE_BYTE,
		UC_LONE_HIGH,
		UC_LONE_LOW,
		UC_ANY,
		UC_PAIR
	} unit_class_t;

	typedef enum int {
		DRAIN_FREE,
		DRAIN_HALF,
		DRAIN_SPARSE,
		DRAIN_STUTTER
	} drain_style_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] code_unit;
	logic        string_end;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        text_done;

	int fail_count;
	int due_count;
	int bytes_checked;
	int burst_left;
	int units_sent;
	int strings_ended;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	utf16_to_utf8_transcoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.code_unit  (code_unit),
		.string_end (string_end),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.text_done  (text_done)
	);

	u16u8_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.string_end    (string_end),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.run_last      (run_last),
		.text_done     (text_done),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.bytes_checked (bytes_checked)
	);

	task automatic send_unit(input logic [15:0] cu, input logic fin);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
		push       <= 1'b1;
		code_unit  <= cu;
		string_end <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
		burst_left--;
		units_sent++;
		if (fin)
			strings_ended++;
	endtask

	function automatic logic [15:0] pick_unit(input unit_class_t cls);
		logic [15:0] cu;
		case (cls)
			UC_ASCII:     cu = 16'($urandom_range(16'h0000, 16'h007F));
			UC_TWO_BYTE:  cu = 16'($urandom_range(16'h0080, 16'h07FF));
			UC_THREE_BYTE: begin
				cu = 16'($urandom_range(16'h0800, 16'hFFFF));
				if (cu >= HIGH_FIRST && cu <= LOW_LAST)
					cu = cu ^ 16'h2000;
			end
			UC_LONE_HIGH: cu = HIGH_FIRST + 16'($urandom_range(0, 1023));
			UC_LONE_LOW:  cu = LOW_FIRST + 16'($urandom_range(0, 1023));
			default:      cu = 16'($urandom_range(0, 16'hFFFF));
		endcase
		return cu;
	endfunction

	// drain side: pop pattern changes style after each random span of steps
	initial begin
		drain_style_t style;
		int span;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			style = drain_style_t'($urandom_range(0, 3));
			span  = $urandom_range(20, 150);
			for (int step = 0; step < span; step++) begin
				@(negedge clk);
				case (style)
					DRAIN_FREE:   pop <= 1'b1;
					DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
					DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
					default:      pop <= (step % 12) < 3;
				endcase
			end
		end
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		unit_class_t cls;
		int pick;
		logic [15:0] lead;
		push          <= 1'b0;
		code_unit     <= 16'h0;
		string_end    <= 1'b0;
		arst_n        <= 1'b0;
		burst_left    = 0;
		units_sent    = 0;
		strings_ended = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// range edges of the one, two and three byte forms
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hD7FF, 1'b0);
		send_unit(16'hE000, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		// lowest and highest surrogate pairs
		send_unit(HIGH_FIRST, 1'b0);
		send_unit(LOW_FIRST, 1'b0);
		send_unit(HIGH_LAST, 1'b0);
		send_unit(LOW_LAST, 1'b0);
		// held high flushed by a plain unit, then by another high
		send_unit(16'hD83D, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(HIGH_LAST, 1'b0);
		send_unit(HIGH_FIRST, 1'b0);
		send_unit(LOW_FIRST, 1'b0);
		// unpaired lows
		send_unit(LOW_FIRST, 1'b0);
		send_unit(LOW_LAST, 1'b0);
		// high surrogate carrying the end mark
		send_unit(16'hDABC, 1'b1);
		// pair closing a string, six-byte flush closing a string, one-unit string
		send_unit(16'hD801, 1'b0);
		send_unit(16'hDC37, 1'b1);
		send_unit(16'hD900, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		send_unit(16'h0041, 1'b1);

		while (units_sent < 469) begin
			pick = $urandom_range(0, 9);
			cls  = (pick > UC_PAIR) ? UC_PAIR : unit_class_t'(pick);
			if (cls == UC_PAIR) begin
				lead = pick_unit(UC_LONE_HIGH);
				send_unit(lead, $urandom_range(0, 15) == 0);
				send_unit(pick_unit(UC_LONE_LOW), $urandom_range(0, 7) == 0);
			end else begin
				send_unit(pick_unit(cls), $urandom_range(0, 7) == 0);
			end
		end
		send_unit(pick_unit(UC_ASCII), 1'b1);
		push <= 1'b0;

		while (due_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("sent %0d code units in %0d strings, checked %0d UTF-8 bytes",
			units_sent, strings_ended, bytes_checked);
		if (fail_count == 0 && due_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
